### hdl/modexp_pkg.sv
// Package: microcode word, opcode and condition codes, and the control store of the modexp unit.
package modexp_pkg;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,     // take an item, set up the base reduction
    OP_DBL,      // acc = 2*acc mod m, shift multiplier, latch its top bit
    OP_ADD,      // acc = acc + (bit ? a : 0) mod m
    OP_SETSQ,    // square register takes the finished product
    OP_SETUP_P,  // set up product * square
    OP_SETP,     // product register takes the finished product
    OP_SETUP_S,  // set up square * square, step the exponent
    OP_EMIT      // hand the result to the output register
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_ITEM,   // no item offered
    COND_DBL_SKIP,  // multiplier bit clear and more bits after this one
    COND_MORE,      // multiplier bits left
    COND_E_CLEAR,   // current exponent bit clear
    COND_E_MORE,    // exponent bits left
    COND_OUT_BUSY   // output register still holds an untaken item
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t tgt_t;  // next step when cond holds
    step_t tgt_f;  // next step otherwise
  } ctrl_t;

  localparam step_t StepWait = 4'd0;

  function automatic ctrl_t rom_word(step_t step);
    ctrl_t w;
    case (step)
      // reduce base: base mod m = (1 mod m) * base
      4'd0:    w = '{OP_LOAD,    COND_NO_ITEM,  4'd0,  4'd1};
      4'd1:    w = '{OP_DBL,     COND_DBL_SKIP, 4'd1,  4'd2};
      4'd2:    w = '{OP_ADD,     COND_MORE,     4'd1,  4'd3};
      4'd3:    w = '{OP_SETSQ,   COND_NEVER,    4'd0,  4'd4};
      // exponent loop head: multiply product by square when the bit is set
      4'd4:    w = '{OP_SETUP_P, COND_E_CLEAR,  4'd8,  4'd5};
      4'd5:    w = '{OP_DBL,     COND_DBL_SKIP, 4'd5,  4'd6};
      4'd6:    w = '{OP_ADD,     COND_MORE,     4'd5,  4'd7};
      4'd7:    w = '{OP_SETP,    COND_NEVER,    4'd0,  4'd8};
      // square
      4'd8:    w = '{OP_SETUP_S, COND_NEVER,    4'd0,  4'd9};
      4'd9:    w = '{OP_DBL,     COND_DBL_SKIP, 4'd9,  4'd10};
      4'd10:   w = '{OP_ADD,     COND_MORE,     4'd9,  4'd11};
      4'd11:   w = '{OP_SETSQ,   COND_E_MORE,   4'd4,  4'd12};
      4'd12:   w = '{OP_EMIT,    COND_OUT_BUSY, 4'd12, 4'd0};
      default: w = '{OP_NOP,     COND_NEVER,    4'd0,  4'd0};
    endcase
    return w;
  endfunction

endpackage

### hdl/modular_exponentiation_unit.sv
// Top level: microcoded square-and-multiply modular exponentiation unit.
//
//  channel | signals                              | direction | item
//  --------+--------------------------------------+-----------+--------------------------
//  in      | in_valid_i, in_stall_o, base_i,       | sink      | base, exponent, modulus
//          | exponent_i, modulus_i                 |           |
//  out     | out_valid_o, out_stall_i, power_mod_o | source    | base^exponent mod modulus
//
// One item at a time. An item takes a load step, then one modular multiply for the
// base reduction, then OPERAND_WIDTH rounds of (optional multiply + square) plus a
// few bookkeeping steps. Each modular multiply runs through the shared add/compare
// unit: OPERAND_WIDTH doubling steps plus one add step per set multiplier bit (plus
// one if the last bit is clear). A round is 3 bookkeeping steps, the square and, for
// a set exponent bit, the multiply and one more step.
// Reset clears the step counter and the output valid; no clearing pass is needed.
// in_stall_o is low only in the wait step. A stalled result sits in the output
// register while the next item is accepted and computed; the sequencer only holds
// at the emit step if the previous result is still untaken.
module modular_exponentiation_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OPERAND_WIDTH-1:0] base_i,
  input  logic [OPERAND_WIDTH-1:0] exponent_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [OPERAND_WIDTH-1:0] power_mod_o
);
  import modexp_pkg::*;

  localparam int CntW = $clog2(OPERAND_WIDTH + 1);
  localparam logic [OPERAND_WIDTH-1:0] One = OPERAND_WIDTH'(1);

  // sequencer
  step_t step_q, step_d;
  ctrl_t cw;
  logic  cond_hit;

  // datapath
  logic [OPERAND_WIDTH-1:0] m_q, m_d;      // modulus
  logic [OPERAND_WIDTH-1:0] e_q, e_d;      // exponent, shifted right per round
  logic [OPERAND_WIDTH-1:0] a_q, a_d;      // multiplicand
  logic [OPERAND_WIDTH-1:0] b_q, b_d;      // multiplier, shifted left per bit
  logic [OPERAND_WIDTH-1:0] acc_q, acc_d;  // running modular product
  logic [OPERAND_WIDTH-1:0] sq_q, sq_d;    // current square of the base
  logic [OPERAND_WIDTH-1:0] prod_q, prod_d;// accumulated result
  logic                     flag_q, flag_d;// multiplier bit latched by the doubling step
  logic [CntW-1:0]          cnt_q, cnt_d;  // multiplier bits left
  logic [CntW-1:0]          ecnt_q, ecnt_d;// exponent bits left

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [OPERAND_WIDTH-1:0] pm_q, pm_d;

  logic                     in_take;
  logic                     out_busy;
  logic                     emit;
  logic [OPERAND_WIDTH-1:0] one_mod;
  logic [OPERAND_WIDTH-1:0] add_y;
  logic [OPERAND_WIDTH:0]   add_sum;
  logic [OPERAND_WIDTH:0]   add_red;
  logic [OPERAND_WIDTH-1:0] mod_sum;

  assign cw         = rom_word(step_q);
  assign in_stall_o = (step_q != StepWait);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  assign emit       = (cw.op == OP_EMIT) && !out_busy;

  // 1 mod m; a zero modulus gives 0 too, so every later value stays 0
  assign one_mod = {{(OPERAND_WIDTH-1){1'b0}}, (modulus_i > One)};

  // shared (x + y) mod m, operands below m, so one conditional subtract suffices
  always_comb begin
    add_y   = (cw.op == OP_DBL) ? acc_q : (flag_q ? a_q : '0);
    add_sum = {1'b0, acc_q} + {1'b0, add_y};
    add_red = (add_sum >= {1'b0, m_q}) ? (add_sum - {1'b0, m_q}) : add_sum;
    mod_sum = add_red[OPERAND_WIDTH-1:0];
  end

  always_comb begin
    case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_NO_ITEM:  cond_hit = !in_valid_i;
      COND_DBL_SKIP: cond_hit = !b_q[OPERAND_WIDTH-1] && (cnt_q != CntW'(1));
      COND_MORE:     cond_hit = (cnt_q != '0);
      COND_E_CLEAR:  cond_hit = !e_q[0];
      COND_E_MORE:   cond_hit = (ecnt_q != '0);
      COND_OUT_BUSY: cond_hit = out_busy;
      default:       cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? cw.tgt_t : cw.tgt_f;
  end

  always_comb begin
    m_d         = m_q;
    e_d         = e_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    prod_d      = prod_q;
    flag_d      = flag_q;
    cnt_d       = cnt_q;
    ecnt_d      = ecnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    pm_d        = pm_q;
    case (cw.op)
      OP_LOAD: begin
        if (in_take) begin
          m_d    = modulus_i;
          e_d    = exponent_i;
          a_d    = one_mod;
          b_d    = base_i;
          acc_d  = '0;
          prod_d = one_mod;
          cnt_d  = CntW'(OPERAND_WIDTH);
          ecnt_d = CntW'(OPERAND_WIDTH);
        end
      end
      OP_DBL: begin
        acc_d  = mod_sum;
        flag_d = b_q[OPERAND_WIDTH-1];
        b_d    = {b_q[OPERAND_WIDTH-2:0], 1'b0};
        cnt_d  = cnt_q - CntW'(1);
      end
      OP_ADD: begin
        acc_d = mod_sum;
      end
      OP_SETSQ: begin
        sq_d = acc_q;
      end
      OP_SETUP_P: begin
        a_d   = prod_q;
        b_d   = sq_q;
        acc_d = '0;
        cnt_d = CntW'(OPERAND_WIDTH);
      end
      OP_SETP: begin
        prod_d = acc_q;
      end
      OP_SETUP_S: begin
        a_d    = sq_q;
        b_d    = sq_q;
        acc_d  = '0;
        cnt_d  = CntW'(OPERAND_WIDTH);
        e_d    = {1'b0, e_q[OPERAND_WIDTH-1:1]};
        ecnt_d = ecnt_q - CntW'(1);
      end
      OP_EMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          pm_d        = prod_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepWait;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ecnt_q      <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ecnt_q      <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    e_q    <= e_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    prod_q <= prod_d;
    flag_q <= flag_d;
    pm_q   <= pm_d;
  end

  assign out_valid_o = out_valid_q;
  assign power_mod_o = pm_q;

endmodule

### bench/modular_exponentiation_unit_test.sv
// Self-checking bench for the square-and-multiply modular exponentiation unit.
`timescale 1ns / 100ps

module modular_exponentiation_unit_test;

  localparam int W = 32;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM = 247;
  localparam int DRAIN_POINT = 60;       // random item after which the sender waits for all results
  localparam int CALM_FIRST = 120;       // random items in this window see no send gaps and no new result stalls
  localparam int CALM_LAST = 159;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic [W-1:0] modulus;
    logic         fixed;      // power_mod below is the answer; otherwise computed
    logic [W-1:0] power_mod;
  } vector_t;

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic [W-1:0] modulus;
    logic [W-1:0] power_mod;
  } pending_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] base_i = '0;
  logic [W-1:0] exponent_i = '0;
  logic [W-1:0] modulus_i = '1;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] power_mod_o;

  pending_result_t pending_results[$];
  int unsigned     mismatch_count = 0;
  int unsigned     results_checked = 0;
  int unsigned     items_sent = 0;
  int unsigned     fixed_rows = 0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_burst = 0;
  bit              calm = 1'b0;

  vector_t directed_rows [NUM_DIRECTED] = '{
    // modulus of one always gives zero
    '{32'd0,          32'd0,          32'd1,          1'b1, 32'd0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1,          1'b1, 32'd0},
    // zero exponent gives one; zero and one to the largest exponent give themselves
    '{32'd5,          32'd0,          32'd7,          1'b1, 32'd1},
    '{32'd0,          32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
    '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd1},
    // base equal to the modulus reduces to zero
    '{32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFF,  1'b1, 32'd0},
    // minus one to odd and even powers, largest possible result
    '{32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFE,  32'd2,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'd2,          32'd10,         32'd1000,       1'b1, 32'd24},
    '{32'd3,          32'd4,          32'hFFFF_FFFF,  1'b1, 32'd81},
    '{32'd2,          32'd31,         32'hFFFF_FFFF,  1'b1, 32'h8000_0000},
    '{32'd3,          32'd5,          32'd2,          1'b1, 32'd1},
    '{32'hFFFF_FFFF,  32'd2,          32'hFFFF_FFFE,  1'b0, 32'd0},
    '{32'd2,          32'd32,         32'hFFFF_FFFF,  1'b0, 32'd0},
    '{32'd7,          32'hFFFF_FFFF,  32'hFFFF_FFFB,  1'b0, 32'd0},
    '{32'd12345,      32'h0001_0001,  32'hFFFF_FFFB,  1'b0, 32'd0},
    '{32'hAAAA_AAAA,  32'h5555_5555,  32'h8000_0000,  1'b0, 32'd0},
    '{32'h5555_5555,  32'hAAAA_AAAA,  32'hFFFF_FFFF,  1'b0, 32'd0},
    '{32'hFFFF_FFFF,  32'h8000_0000,  32'd3,          1'b0, 32'd0},
    '{32'h8000_0000,  32'hFFFF_FFFF,  32'h7FFF_FFFF,  1'b0, 32'd0},
    '{32'hDEAD_BEEF,  32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, 32'd0}
  };

  modular_exponentiation_unit #(
    .OPERAND_WIDTH(W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .modulus_i  (modulus_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .power_mod_o(power_mod_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Square-and-multiply in 64-bit arithmetic; operands stay below the modulus,
  // so every product fits before the reduction.
  function automatic logic [W-1:0] power_mod_of(logic [W-1:0] b, logic [W-1:0] e,
                                                logic [W-1:0] m);
    logic [63:0] sq;
    logic [63:0] acc;
    sq = 64'(b) % 64'(m);
    acc = 64'd1 % 64'(m);
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = (acc * sq) % 64'(m);
      sq = (sq * sq) % 64'(m);
    end
    return acc[W-1:0];
  endfunction

  function automatic logic [W-1:0] nonzero_word();
    logic [W-1:0] w;
    do w = $urandom; while (w == '0);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
  endtask

  task automatic check_result(input logic [W-1:0] got);
    pending_result_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", got, 'x);
    end else begin
      want = pending_results.pop_front();
      if (got !== want.power_mod)
        report_mismatch($sformatf("power_mod for %h^%h mod %h", want.base, want.exponent,
                                  want.modulus), got, want.power_mod);
    end
  endtask

  // Drives one item after an optional idle gap and returns at the accepting edge.
  task automatic send_item(input logic [W-1:0] b, input logic [W-1:0] e,
                           input logic [W-1:0] m, input logic fixed,
                           input logic [W-1:0] answer);
    int unsigned gap;
    pending_result_t entry;
    gap = 0;
    if (!calm && $urandom_range(99) < 18)
      gap = ($urandom_range(9) == 0) ? $urandom_range(3000, 100) : $urandom_range(40, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_i <= b;
    exponent_i <= e;
    modulus_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    entry.base = b;
    entry.exponent = e;
    entry.modulus = m;
    entry.power_mod = fixed ? answer : power_mod_of(b, e, m);
    pending_results.push_back(entry);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, an occasional long hold that backs the unit up
  // at its emit step, none started during the calm window.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(power_mod_o);
    if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall_i <= 1'b1;
    end else if (calm || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(19999) == 0) begin
      stall_burst <= $urandom_range(3000, 200);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] m;
    int unsigned  pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].base, directed_rows[i].exponent, directed_rows[i].modulus,
                directed_rows[i].fixed, directed_rows[i].power_mod);
      if (directed_rows[i].fixed) fixed_rows++;
    end
    wait_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= CALM_FIRST && n <= CALM_LAST);
      pick = $urandom_range(99);
      b = $urandom;
      e = $urandom;
      m = nonzero_word();
      if (pick < 55) begin
        // fully random operands
      end else if (pick < 70) begin
        m = $urandom_range(255, 1);
      end else if (pick < 80) begin
        e = $urandom_range(15);
      end else if (pick < 86) begin
        m = 1;
      end else if (pick < 92) begin
        e = '0;
      end else begin
        // modulus near the top, base around it
        m = '1 - $urandom_range(15);
        b = m + $urandom_range(2) - 1;
      end
      send_item(b, e, m, 1'b0, '0);
      if (n == DRAIN_POINT) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", '0, pending_results.size());

    $display("Covered %0d items: %0d directed (%0d with fixed answers), the rest random",
             items_sent, NUM_DIRECTED, fixed_rows);
    $display("%0d results checked in %0d cycles, %0d mismatches", results_checked,
             cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
